>>> sv/bat_pkg.sv
// Shared definitions for the buddy allocator: default sizes, status codes,
// controller states and the size-to-exponent rounding function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bat_pkg;

    localparam int TOTAL_EXP_DEF = 16;
    localparam int BLOCK_EXP_DEF = 6;

    localparam int SIZE_W = 17;
    localparam int OFF_W  = 16;
    localparam int EXP_W  = 5;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOMEM    = 2'd1,
        ST_ZERO     = 2'd2,
        ST_NOTALLOC = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_A_ROOT,
        S_A_DESC,
        S_F_UP,
        S_CLIMB,
        S_DONE
    } t_state;

    // Smallest exponent whose power of two holds the requested size.
    function automatic logic [EXP_W-1:0] ceil_log2(input logic [SIZE_W-1:0] size);
        logic [EXP_W-1:0] req;
        req = EXP_W'(SIZE_W);
        for (int r = SIZE_W - 1; r >= 0; r--) begin
            if ((SIZE_W'(1) << r) >= size) begin
                req = EXP_W'(r);
            end
        end
        return req;
    endfunction

endpackage

`default_nettype wire

>>> sv/buddy_allocator_tree.sv
// Binary buddy allocator: tree memory, walk controller and result register.
// Depends on bat_pkg for status codes, states and the rounding function.
//
// Walk: an allocate reads down the tree from the root and, unless it takes the whole pool,
// climbs back to update the parents; a free climbs from its leaf to the allocated node and
// then merges upwards. Zero-size and no-memory answers stop after the root read.
// Throughput: one request at a time; a new one is taken in the cycle after the previous result
// is loaded. Each tree level costs one tree-memory read, plus one write on the merge climb.
// Reset: synchronous, active low; afterwards a clearing pass writes every tree node
// (2^(LEAF_LEVELS+1)-1 nodes, 2047 at the defaults) while no request is taken.
`timescale 1ns / 1ps
`default_nettype none

module buddy_allocator_tree
    import bat_pkg::*;
#(
    parameter int TOTAL_EXP = TOTAL_EXP_DEF,
    parameter int BLOCK_EXP = BLOCK_EXP_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // request channel
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_command,
    input  wire logic [SIZE_W-1:0] i_req_size,
    input  wire logic [OFF_W-1:0]  i_block_offset,
    // result channel
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [1:0]             o_status,
    output logic [OFF_W-1:0]       o_offset,
    output logic [EXP_W-1:0]       o_block_exp,
    output logic [SIZE_W-1:0]      o_used_bytes
);

    // Tree geometry. Node 0 is the root; the children of node i are 2i+1 and 2i+2.
    localparam int LEAF_LEVELS = TOTAL_EXP - BLOCK_EXP;
    localparam int NW          = LEAF_LEVELS + 1;
    localparam int unsigned NODE_COUNT = (32'd1 << NW) - 32'd1;
    localparam int unsigned FIRST_LEAF = (32'd1 << LEAF_LEVELS) - 32'd1;
    localparam int UW          = TOTAL_EXP + 1;
    localparam int OW          = TOTAL_EXP;

    localparam logic [EXP_W-1:0] EXP_TOT = EXP_W'(TOTAL_EXP);
    localparam logic [EXP_W-1:0] EXP_BLK = EXP_W'(BLOCK_EXP);

    // Each entry holds e+1 when the largest free block below the node is 2^e bytes,
    // and zero when nothing below it is free.
    logic [EXP_W-1:0] r_tree [NODE_COUNT];
    logic [EXP_W-1:0] r_rdata;

    logic             mem_we;
    logic [NW-1:0]    mem_waddr;
    logic [EXP_W-1:0] mem_wdata;
    logic             mem_re;
    logic [NW-1:0]    mem_raddr;

    t_state r_state, n_state;

    logic [NW-1:0]     r_clr_addr, n_clr_addr;
    logic [EXP_W-1:0]  r_clr_val,  n_clr_val;

    logic [EXP_W-1:0]  r_req,  n_req;
    logic              r_zero, n_zero;
    logic [NW-1:0]     r_node, n_node;
    logic [EXP_W-1:0]  r_cval, n_cval;
    logic [EXP_W-1:0]  r_ns,   n_ns;
    logic [OFF_W-1:0]  r_foff, n_foff;
    logic [OW-1:0]     r_aoff, n_aoff;
    logic [UW-1:0]     r_used, n_used;

    t_status           r_res_status, n_res_status;
    logic [OFF_W-1:0]  r_res_off,    n_res_off;
    logic [EXP_W-1:0]  r_res_exp,    n_res_exp;

    logic              r_o_valid,  n_o_valid;
    t_status           r_o_status, n_o_status;
    logic [OFF_W-1:0]  r_o_off,    n_o_off;
    logic [EXP_W-1:0]  r_o_exp,    n_o_exp;
    logic [SIZE_W-1:0] r_o_used,   n_o_used;

    // Helpers shared by the next-state and datapath logic.
    logic              in_acc;
    logic              out_free;
    logic              clr_last;
    logic              clr_step;
    logic [EXP_W-1:0]  req_in;
    logic              off_range;
    logic [NW-1:0]     leaf_in;
    logic              go_right;
    logic [NW-1:0]     pick;
    logic [NW-1:0]     pick_left;
    logic [NW-1:0]     pick_sib;
    logic [NW-1:0]     parent;
    logic [NW-1:0]     parent_sib;
    logic [NW-1:0]     node_sib;
    logic [EXP_W-1:0]  kid_l, kid_r;
    logic [EXP_W-1:0]  merged;
    logic [UW-1:0]     blk_bytes;
    logic [OFF_W-1:0]  free_mask;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_o_valid || !i_out_stall;

    // The level value drops by one after each node whose index plus two is a power of two.
    assign clr_last = (r_clr_addr == NW'(NODE_COUNT - 32'd1));
    assign clr_step = (((NW+1)'(r_clr_addr) + (NW+1)'(2)) &
                       ((NW+1)'(r_clr_addr) + (NW+1)'(1))) == '0;

    always_comb begin
        req_in = ceil_log2(i_req_size);
        if (req_in < EXP_BLK) begin
            req_in = EXP_BLK;
        end
    end

    assign off_range = (32'(i_block_offset) >> TOTAL_EXP) == 32'd0;
    assign leaf_in   = NW'((32'(i_block_offset) >> BLOCK_EXP) + FIRST_LEAF);

    // Descent: r_node is the left child just read; step right when it cannot hold the block.
    assign go_right  = (r_rdata <= r_req);
    assign pick      = go_right ? r_node + NW'(1) : r_node;
    assign pick_left = NW'({pick, 1'b1});
    assign pick_sib  = pick[0] ? pick + NW'(1) : pick - NW'(1);

    // Climb: r_node is the child whose value is known; the sibling has just been read.
    assign parent     = (r_node - NW'(1)) >> 1;
    assign parent_sib = parent[0] ? parent + NW'(1) : parent - NW'(1);
    assign node_sib   = r_node[0] ? r_node + NW'(1) : r_node - NW'(1);
    assign kid_l      = r_node[0] ? r_cval : r_rdata;
    assign kid_r      = r_node[0] ? r_rdata : r_cval;

    always_comb begin
        if (kid_l == r_ns + EXP_W'(1) && kid_r == r_ns + EXP_W'(1)) begin
            merged = r_ns + EXP_W'(2);
        end else if (kid_l > kid_r) begin
            merged = kid_l;
        end else begin
            merged = kid_r;
        end
    end

    assign blk_bytes = UW'(1) << r_ns;
    assign free_mask = ~((OFF_W'(1) << r_ns) - OFF_W'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR: begin
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    if (!i_command) begin
                        n_state = S_A_ROOT;
                    end else if (off_range) begin
                        n_state = S_F_UP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_A_ROOT: begin
                if (!r_zero && r_req < EXP_TOT && r_rdata > r_req) begin
                    n_state = S_A_DESC;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_A_DESC: begin
                if (r_ns == r_req) begin
                    n_state = S_CLIMB;
                end
            end
            S_F_UP: begin
                if (r_node == '0) begin
                    n_state = S_DONE;
                end else if (r_rdata == '0) begin
                    n_state = S_CLIMB;
                end
            end
            S_CLIMB: begin
                if (parent == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    // Memory controls and datapath registers.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_node;
        mem_wdata = '0;
        mem_re    = 1'b0;
        mem_raddr = '0;

        n_clr_addr   = r_clr_addr;
        n_clr_val    = r_clr_val;
        n_req        = r_req;
        n_zero       = r_zero;
        n_node       = r_node;
        n_cval       = r_cval;
        n_ns         = r_ns;
        n_foff       = r_foff;
        n_aoff       = r_aoff;
        n_used       = r_used;
        n_res_status = r_res_status;
        n_res_off    = r_res_off;
        n_res_exp    = r_res_exp;

        n_o_valid  = r_o_valid && i_out_stall;
        n_o_status = r_o_status;
        n_o_off    = r_o_off;
        n_o_exp    = r_o_exp;
        n_o_used   = r_o_used;

        case (r_state)
            S_CLR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = r_clr_val;
                n_clr_addr = r_clr_addr + NW'(1);
                if (clr_step) begin
                    n_clr_val = r_clr_val - EXP_W'(1);
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_res_status = ST_OK;
                    n_res_off    = '0;
                    n_res_exp    = '0;
                    if (!i_command) begin
                        mem_re    = 1'b1;
                        mem_raddr = '0;
                        n_req     = req_in;
                        n_zero    = (i_req_size == '0);
                        n_node    = '0;
                        n_ns      = EXP_TOT;
                        n_aoff    = '0;
                    end else if (off_range) begin
                        mem_re    = 1'b1;
                        mem_raddr = leaf_in;
                        n_node    = leaf_in;
                        n_ns      = EXP_BLK;
                        n_foff    = i_block_offset;
                    end else begin
                        n_res_status = ST_NOTALLOC;
                    end
                end
            end
            S_A_ROOT: begin
                if (r_zero) begin
                    n_res_status = ST_ZERO;
                end else if (r_req > EXP_TOT || r_rdata <= r_req) begin
                    n_res_status = ST_NOMEM;
                end else if (r_req == EXP_TOT) begin
                    // The whole pool is handed out: only the root changes.
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = '0;
                    n_used    = r_used + blk_bytes;
                    n_res_exp = EXP_TOT;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = NW'(1);
                    n_node    = NW'(1);
                    n_ns      = r_ns - EXP_W'(1);
                end
            end
            S_A_DESC: begin
                n_aoff = go_right ? r_aoff | (OW'(1) << r_ns) : r_aoff;
                if (r_ns == r_req) begin
                    mem_we    = 1'b1;
                    mem_waddr = pick;
                    mem_wdata = '0;
                    mem_re    = 1'b1;
                    mem_raddr = pick_sib;
                    n_node    = pick;
                    n_cval    = '0;
                    n_used    = r_used + blk_bytes;
                    n_res_off = OFF_W'(n_aoff);
                    n_res_exp = r_ns;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = pick_left;
                    n_node    = pick_left;
                    n_ns      = r_ns - EXP_W'(1);
                end
            end
            S_F_UP: begin
                if (r_rdata != '0) begin
                    if (r_node == '0) begin
                        n_res_status = ST_NOTALLOC;
                    end else begin
                        mem_re    = 1'b1;
                        mem_raddr = parent;
                        n_node    = parent;
                        n_ns      = r_ns + EXP_W'(1);
                    end
                end else begin
                    // Found the allocated node: it becomes a whole free block again.
                    mem_we    = 1'b1;
                    mem_waddr = r_node;
                    mem_wdata = r_ns + EXP_W'(1);
                    mem_re    = (r_node != '0);
                    mem_raddr = node_sib;
                    n_cval    = r_ns + EXP_W'(1);
                    n_used    = r_used - blk_bytes;
                    n_res_off = r_foff & free_mask;
                    n_res_exp = r_ns;
                end
            end
            S_CLIMB: begin
                mem_we    = 1'b1;
                mem_waddr = parent;
                mem_wdata = merged;
                mem_re    = (parent != '0);
                mem_raddr = parent_sib;
                n_node    = parent;
                n_cval    = merged;
                n_ns      = r_ns + EXP_W'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_off    = r_res_off;
                    n_o_exp    = r_res_exp;
                    n_o_used   = SIZE_W'(r_used);
                end
            end
            default: begin
            end
        endcase
    end

    // Tree memory: one write port, one read port, registered read data.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tree[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_tree[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_clr_val  <= EXP_TOT + EXP_W'(1);
            r_used     <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_clr_val  <= n_clr_val;
            r_used     <= n_used;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_zero       <= n_zero;
        r_node       <= n_node;
        r_cval       <= n_cval;
        r_ns         <= n_ns;
        r_foff       <= n_foff;
        r_aoff       <= n_aoff;
        r_res_status <= n_res_status;
        r_res_off    <= n_res_off;
        r_res_exp    <= n_res_exp;
        r_o_status   <= n_o_status;
        r_o_off      <= n_o_off;
        r_o_exp      <= n_o_exp;
        r_o_used     <= n_o_used;
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_o_valid;
    assign o_status     = r_o_status;
    assign o_offset     = r_o_off;
    assign o_block_exp  = r_o_exp;
    assign o_used_bytes = r_o_used;

    // A node is never read in the cycle in which it is written.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("tree read and write hit the same node");

    // An accepted request always starts a walk or goes straight to its result.
    a_leave_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != S_IDLE && r_state != S_CLR))
        else $error("accepted request left the controller idle");

    // The allocated total never exceeds the pool.
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= (UW'(1) << TOTAL_EXP))
        else $error("allocated byte count exceeds the pool");

    // Walks never pass the root level: the free search may stand on the root itself,
    // while the merge climb always holds a child below it.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_F_UP) ? (r_ns <= EXP_TOT) : (r_state != S_CLIMB || r_ns < EXP_TOT))
        else $error("tree walk went above the root level");

    // A result is loaded only from the completion state.
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_o_valid && n_o_valid) |-> (r_state == S_DONE))
        else $error("result loaded outside the completion state");

endmodule

`default_nettype wire

>>> sim/buddy_allocator_tree_tb.sv
// Self-checking testbench for buddy_allocator_tree: random and directed allocate and free
// requests, scored against a bit-accurate predictor of the largest-free-block tree.
// Depends on bat_pkg (status codes, field widths, default sizes) and the allocator RTL.
`timescale 1ns / 1ps
`default_nettype none

module buddy_allocator_tree_tb;
    import bat_pkg::*;

    // Pool geometry, taken from the package defaults so that the predictor and the block agree.
    localparam int TOTAL_EXP   = TOTAL_EXP_DEF;
    localparam int BLOCK_EXP   = BLOCK_EXP_DEF;
    localparam int LEAF_LEVELS = TOTAL_EXP - BLOCK_EXP;
    localparam int NODES       = (1 << (LEAF_LEVELS + 1)) - 1;
    localparam int FIRST_LEAF  = (1 << LEAF_LEVELS) - 1;

    // Run shape. The stuck limit covers the clearing pass after reset (a write to every tree
    // node), the long receiver hold-off and the slowest walk, several times over.
    localparam int ITEMS       = 1700;
    localparam int QUIET_ITEMS = 150;
    localparam int HOLD_AT     = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 40;
    localparam int STUCK_LIMIT = 8000;
    localparam int MAX_REPORTS = 10;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_command;

    typedef struct packed {
        t_status           status;
        logic [OFF_W-1:0]  offset;
        logic [EXP_W-1:0]  block_exp;
        logic [SIZE_W-1:0] used_bytes;
    } t_result;

    // A block that is currently handed out, kept so that frees can aim at live allocations.
    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [EXP_W-1:0] exp;
    } t_block;

    // The scoreboard carries its own copy of the allocation tree. Each tree entry holds
    // e+1 when the largest free block beneath the node is 2^e bytes, and 0 when nothing
    // beneath it is free, exactly as the block keeps it.
    class buddy_scoreboard;
        logic [EXP_W-1:0]  largest_free [NODES];
        logic [SIZE_W-1:0] bytes_in_use;
        t_result           awaited_q[$];
        t_block            live_q[$];
        int                fails;

        function new();
            int level_val;
            level_val = TOTAL_EXP + 1;
            for (int n = 0; n < NODES; n++) begin
                largest_free[n] = EXP_W'(level_val);
                // The last node of each tree level is followed by the next, smaller level.
                if ((((n + 2) & (n + 1)) == 0) && level_val > 0) begin
                    level_val--;
                end
            end
            bytes_in_use = '0;
            fails        = 0;
        endfunction

        // Works out the answer to one accepted request and queues it.
        function void note_request(t_command cmd, logic [SIZE_W-1:0] size,
                                   logic [OFF_W-1:0] off);
            t_result     r;
            int          req;
            int          ns;
            int          node;
            bit          found;
            logic [EXP_W-1:0] lft;
            logic [EXP_W-1:0] rgt;
            r = '{status: ST_OK, offset: '0, block_exp: '0, used_bytes: '0};
            if (cmd == CMD_ALLOC) begin
                if (size == '0) begin
                    r.status = ST_ZERO;
                end else begin
                    req = 0;
                    while (req < 40 && (64'd1 << req) < 64'(size)) begin
                        req++;
                    end
                    if (req < BLOCK_EXP) begin
                        req = BLOCK_EXP;
                    end
                    if (req > TOTAL_EXP || int'(largest_free[0]) < req + 1) begin
                        r.status = ST_NOMEM;
                    end else begin
                        // Walk down, taking the left child whenever it can hold the block.
                        node = 0;
                        for (ns = TOTAL_EXP; ns > req; ns--) begin
                            node = 2 * node + 1;
                            if (int'(largest_free[node]) < req + 1) begin
                                node++;
                            end
                        end
                        largest_free[node] = '0;
                        bytes_in_use += SIZE_W'(64'd1 << ns);
                        r.offset    = OFF_W'((longint'(node + 1) << ns) -
                                             (longint'(1) << TOTAL_EXP));
                        r.block_exp = EXP_W'(ns);
                        live_q.push_back('{start: r.offset, exp: r.block_exp});
                        while (node != 0) begin
                            node = (node + 1) / 2 - 1;
                            lft  = largest_free[2 * node + 1];
                            rgt  = largest_free[2 * node + 2];
                            largest_free[node] = (lft > rgt) ? lft : rgt;
                        end
                    end
                end
            end else begin
                found = 1'b0;
                if (longint'(off) < (longint'(1) << TOTAL_EXP)) begin
                    // Climb from the leaf under the offset to the node that was handed out.
                    node  = int'(off >> BLOCK_EXP) + FIRST_LEAF;
                    ns    = BLOCK_EXP;
                    found = 1'b1;
                    while (largest_free[node] != '0) begin
                        if (node == 0) begin
                            found = 1'b0;
                            break;
                        end
                        node = (node + 1) / 2 - 1;
                        ns++;
                    end
                end
                if (!found) begin
                    r.status = ST_NOTALLOC;
                end else begin
                    r.block_exp = EXP_W'(ns);
                    r.offset    = OFF_W'((longint'(node + 1) << ns) -
                                         (longint'(1) << TOTAL_EXP));
                    largest_free[node] = EXP_W'(ns + 1);
                    bytes_in_use -= SIZE_W'(64'd1 << ns);
                    for (int k = 0; k < live_q.size(); k++) begin
                        if (live_q[k].start == r.offset) begin
                            live_q.delete(k);
                            break;
                        end
                    end
                    // Merge buddies: two wholly free halves make one free parent.
                    while (node != 0) begin
                        node = (node + 1) / 2 - 1;
                        lft  = largest_free[2 * node + 1];
                        rgt  = largest_free[2 * node + 2];
                        if (int'(lft) == ns + 1 && int'(rgt) == ns + 1) begin
                            largest_free[node] = EXP_W'(ns + 2);
                        end else begin
                            largest_free[node] = (lft > rgt) ? lft : rgt;
                        end
                        ns++;
                    end
                end
            end
            r.used_bytes = bytes_in_use;
            awaited_q.push_back(r);
        endfunction

        // Compares one accepted result with the oldest awaited answer.
        function void check_result(logic [1:0] status, logic [OFF_W-1:0] offset,
                                   logic [EXP_W-1:0] block_exp, logic [SIZE_W-1:0] used);
            t_result e;
            if (awaited_q.size() == 0) begin
                fails++;
                if (fails <= MAX_REPORTS) begin
                    $display("%0t: result with no request outstanding: st=%0d off=%h exp=%0d used=%0d",
                             $realtime, status, offset, block_exp, used);
                end
            end else begin
                e = awaited_q.pop_front();
                if (status !== e.status || offset !== e.offset ||
                    block_exp !== e.block_exp || used !== e.used_bytes) begin
                    fails++;
                    if (fails <= MAX_REPORTS) begin
                        $display("%0t: mismatch: expected st=%0d off=%h exp=%0d used=%0d, got st=%0d off=%h exp=%0d used=%0d",
                                 $realtime, e.status, e.offset, e.block_exp, e.used_bytes,
                                 status, offset, block_exp, used);
                    end
                end
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic              i_command;
    logic [SIZE_W-1:0] i_req_size;
    logic [OFF_W-1:0]  i_block_offset;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [1:0]        o_status;
    logic [OFF_W-1:0]  o_offset;
    logic [EXP_W-1:0]  o_block_exp;
    logic [SIZE_W-1:0] o_used_bytes;

    buddy_scoreboard sb = new();

    // Shared between the request side and the result side.
    bit quiet        = 1'b0;   // last part of the run: nobody idles
    bit hold_pending = 1'b0;   // asks the result side for one long hold-off
    int gap_pct      = 30;     // chance of an idle burst after each request
    int n_sent       = 0;
    int stuck_cycles = 0;

    buddy_allocator_tree #(
        .TOTAL_EXP(TOTAL_EXP),
        .BLOCK_EXP(BLOCK_EXP)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_req_size    (i_req_size),
        .i_block_offset(i_block_offset),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_offset      (o_offset),
        .o_block_exp   (o_block_exp),
        .o_used_bytes  (o_used_bytes)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offers one request and holds it until the block takes it. The request is noted in the
    // scoreboard at the accepting edge, so the next request is always chosen from an
    // up-to-date picture of the pool. An idle burst may follow; otherwise the caller's next
    // request keeps valid high without lowering it in between.
    task automatic issue_request(input t_command cmd, input logic [SIZE_W-1:0] size,
                                 input logic [OFF_W-1:0] off);
        i_command      <= cmd;
        i_req_size     <= size;
        i_block_offset <= off;
        i_in_valid     <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        sb.note_request(cmd, size, off);
        n_sent++;
        if (!quiet && $urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    // The offset is ignored on an allocate and the size on a free, so those carry noise.
    task automatic alloc_req(input logic [SIZE_W-1:0] size);
        issue_request(CMD_ALLOC, size, OFF_W'($urandom));
    endtask

    task automatic free_req(input logic [OFF_W-1:0] off);
        issue_request(CMD_FREE, SIZE_W'($urandom), off);
    endtask

    // Request side: reset, a directed opening, then random traffic in phases.
    initial begin : request_side
        int     alloc_pct;
        int     sel;
        t_block blk;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  off;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_command      <= CMD_ALLOC;
        i_req_size     <= '0;
        i_block_offset <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening. Rejections first on a fresh pool, then the whole pool as one
        // block, a free from inside a block, a mix of sizes and finally a full merge.
        alloc_req('0);                  // zero size
        alloc_req({SIZE_W{1'b1}});      // every size bit set: far too large
        alloc_req(SIZE_W'(65537));      // one byte over the pool
        free_req('0);                   // nothing allocated yet
        free_req({OFF_W{1'b1}});
        alloc_req(SIZE_W'(65536));      // the whole pool
        alloc_req(SIZE_W'(1));          // pool is full
        free_req(OFF_W'(12345));        // inside the whole-pool block
        alloc_req(SIZE_W'(1));          // rounds up to the smallest block
        alloc_req(SIZE_W'(64));
        alloc_req(SIZE_W'(65));         // rounds up to the next power of two
        alloc_req(SIZE_W'(32768));
        alloc_req(SIZE_W'(32768));      // no half of the pool is left
        free_req(OFF_W'(70));           // inside the block at 64
        free_req(OFF_W'(70));           // the same space once more: not allocated
        alloc_req(SIZE_W'(16384));
        free_req(OFF_W'(33768));
        free_req(OFF_W'(0));
        free_req(OFF_W'(128));
        free_req(OFF_W'(16384));        // the pool merges back into one block
        alloc_req(SIZE_W'(65536));
        free_req({OFF_W{1'b1}});
        free_req({OFF_W{1'b1}});

        // Random part. Each phase leans towards allocating or towards freeing, so that the
        // pool fills up to the no-memory answers and drains back through the buddy merges.
        alloc_pct = 60;
        while (n_sent < ITEMS) begin
            if (n_sent % 100 == 0) begin
                sel = $urandom_range(0, 3);
                alloc_pct = (sel == 0) ? 25 : (sel == 1) ? 55 : (sel == 2) ? 80 : 97;
                sel = $urandom_range(0, 2);
                gap_pct = (sel == 0) ? 0 : (sel == 1) ? 20 : 45;
            end
            if (n_sent == HOLD_AT) begin
                hold_pending = 1'b1;
            end
            if (n_sent >= ITEMS - QUIET_ITEMS) begin
                quiet = 1'b1;
            end
            if ($urandom_range(0, 99) < alloc_pct) begin
                // Mostly small blocks, which give deep walks and many live allocations.
                sel = $urandom_range(0, 99);
                if (sel < 3) begin
                    size = '0;
                end else if (sel < 5) begin
                    size = SIZE_W'($urandom_range(0, (1 << SIZE_W) - 1));
                end else if (sel < 10) begin
                    size = SIZE_W'($urandom_range(1, 1 << TOTAL_EXP));
                end else if (sel < 30) begin
                    size = SIZE_W'($urandom_range(513, 8192));
                end else begin
                    size = SIZE_W'($urandom_range(1, 512));
                end
                alloc_req(size);
            end else begin
                // Mostly frees of some byte inside a live block; the rest hit anywhere.
                if (sb.live_q.size() != 0 && $urandom_range(0, 99) < 85) begin
                    blk = sb.live_q[$urandom_range(0, sb.live_q.size() - 1)];
                    off = blk.start + OFF_W'($urandom_range(0, (1 << blk.exp) - 1));
                end else begin
                    off = OFF_W'($urandom_range(0, (1 << OFF_W) - 1));
                end
                free_req(off);
            end
        end
        i_in_valid <= 1'b0;

        // Wait for every answer, then a little longer for any stray result.
        while (sb.awaited_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);
        if (sb.fails == 0 && sb.awaited_q.size() == 0) begin
            $display("buddy_allocator_tree_tb passed");
        end else begin
            $display("buddy_allocator_tree_tb failed");
        end
        $finish;
    end

    // Result side: random stall bursts, one long hold-off while requests keep coming so that
    // the block backs up onto its input, and no stalls at all once the run turns quiet.
    initial begin : result_side
        int n;
        i_out_stall <= 1'b0;
        forever begin
            if (quiet) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if (hold_pending) begin
                hold_pending = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if ($urandom_range(0, 9) == 0) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(40, 120)) @(posedge i_clk);
            end else begin
                n = $urandom_range(1, 17);
                i_out_stall <= ($urandom_range(0, 2) == 0);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // Results are sampled at the edge on the values that held just before it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(o_status, o_offset, o_block_exp, o_used_bytes);
        end
    end

    // Watchdog: too many cycles in a row with no request and no result moving means a hang.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("buddy_allocator_tree_tb failed");
                $finish;
            end
        end
    end

endmodule

`default_nettype wire
